// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RN_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define RN_ASSERT(label, prop, msg) \
  `RN_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// ===== hw/rtl/rmsn_pkg.sv =====
// Package of the RMS normalizer: default sizes, register reset and controller states.
package rmsn_pkg;

  localparam int unsigned MaxLenDefault    = 64;
  localparam int unsigned DataWidthDefault = 16;
  localparam int unsigned EpsWidth         = 16;
  localparam logic [EpsWidth-1:0] EpsReset = 16'd17;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MSDIV,
    ST_SQRT,
    ST_RD,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// ===== hw/rtl/rms_normalizer.sv =====
// RMS normalizer: buffers a vector, computes its RMS and emits the scaled elements.
//
// Input channel (sample_i, gain_i, final_req_i) and output channel (normalized_o,
// end_of_vector_o, truncated_o) use valid/stall: a transaction completes on a
// clock edge with valid high and stall low. epsilon_i is written when
// epsilon_we_i is high; the user must write it only while the block is idle,
// the block itself does not enforce this. The buffer holds MAX_LEN elements;
// later ones are dropped and flag truncated_o on every result of that vector.
// After the transaction marked final_req_i the block stalls its input, divides
// the square sum by the count (one quotient bit per cycle on a shared
// restoring divider), takes the square root (one root bit per step), then per
// element: buffer RAM read, multiply, round, divide on the same divider and
// hand-off to the output register. DV_W = 2*DATA_WIDTH + clog2(MAX_LEN+1),
// i.e. 39 at the defaults. The divider sets the rate.
// The output register decouples the sides: a stall on the output only holds
// the current result and delays the next one. Input is accepted again once the
// last result of the vector sits in the output register.
// Reset clears the sum, count, overflow flag and result valid and sets epsilon
// to 17; the buffer RAM is not cleared, each entry is written before it is read.
module rms_normalizer #(
  parameter int unsigned MAX_LEN    = rmsn_pkg::MaxLenDefault,
  parameter int unsigned DATA_WIDTH = rmsn_pkg::DataWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          epsilon_we_i,
  input  logic [rmsn_pkg::EpsWidth-1:0] epsilon_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [DATA_WIDTH-1:0]  sample_i,
  input  logic signed [DATA_WIDTH-1:0]  gain_i,
  input  logic                          final_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [DATA_WIDTH-1:0]  normalized_o,
  output logic                          end_of_vector_o,
  output logic                          truncated_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned PROD_W = 2 * DATA_WIDTH;
  localparam int unsigned DV_W   = PROD_W + CNT_W;
  localparam int unsigned SQ_W   = DV_W + (DV_W % 2);
  localparam int unsigned RT_W   = SQ_W / 2;
  localparam int unsigned STEP_W = $clog2(DV_W + 1);
  localparam int unsigned EPS_W  = rmsn_pkg::EpsWidth;

  localparam logic [DV_W-1:0] MaxPos = DV_W'((1 << (DATA_WIDTH - 1)) - 1);
  localparam logic [DV_W-1:0] MaxNeg = DV_W'(1 << (DATA_WIDTH - 1));

  rmsn_pkg::state_e state_q, state_d;

  logic [EPS_W-1:0]  eps_q, eps_d;
  logic [DV_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [DV_W-1:0]   dnum_q, dnum_d;
  logic [RT_W-1:0]   drem_q, drem_d;
  logic [RT_W-1:0]   dvs_q, dvs_d;

  logic [SQ_W-1:0]   sval_q, sval_d;
  logic [RT_W+1:0]   srem_q, srem_d;
  logic [RT_W-1:0]   root_q, root_d;

  logic [PROD_W-1:0] mag_q, mag_d;
  logic              neg_q, neg_d;

  logic                  ov_q, ov_d;
  logic [DATA_WIDTH-1:0] res_q, res_d;
  logic                  eov_q, eov_d;
  logic                  trn_q, trn_d;

  // Divider step
  logic [RT_W:0]   rem_sh, rem_nx;
  logic            q_bit;
  assign rem_sh = {drem_q, dnum_q[DV_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dvs_q});
  assign rem_nx = q_bit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  // Square root step
  logic [RT_W+1:0] s_rem_t, s_trial;
  logic            s_ge;
  assign s_rem_t = {srem_q[RT_W-1:0], sval_q[SQ_W-1 -: 2]};
  assign s_trial = {root_q, 2'b01};
  assign s_ge    = (s_rem_t >= s_trial);

  // Buffer
  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [PROD_W-1:0]     ram_rdata;
  logic signed [DATA_WIDTH-1:0] rd_x, rd_w;
  logic signed [PROD_W-1:0]     sq_in, prod;

  assign ram_raddr = idx_q[AW-1:0];
  assign rd_x      = ram_rdata[PROD_W-1 -: DATA_WIDTH];
  assign rd_w      = ram_rdata[DATA_WIDTH-1:0];
  assign sq_in     = sample_i * sample_i;
  assign prod      = rd_x * rd_w;

  rmsn_ram #(
    .WIDTH(PROD_W),
    .DEPTH(MAX_LEN)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i({sample_i, gain_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic in_acc, out_free, room;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !ov_q || !out_stall_i;
  assign room     = (cnt_q < CNT_W'(MAX_LEN));
  assign ram_we   = in_acc && room;

  always_comb begin
    state_d = state_q;
    eps_d   = epsilon_we_i ? epsilon_i : eps_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    idx_d   = idx_q;
    step_d  = step_q;
    dnum_d  = dnum_q;
    drem_d  = drem_q;
    dvs_d   = dvs_q;
    sval_d  = sval_q;
    srem_d  = srem_q;
    root_d  = root_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    ov_d    = ov_q && out_stall_i;
    res_d   = res_q;
    eov_d   = eov_q;
    trn_d   = trn_q;
    in_stall_o = (state_q != rmsn_pkg::ST_LOAD);

    unique case (state_q)
      rmsn_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (room) begin
            sum_d = sum_q + DV_W'($unsigned(sq_in));
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (final_req_i) begin
            dnum_d  = sum_d;
            drem_d  = '0;
            dvs_d   = RT_W'(cnt_d);
            step_d  = '0;
            state_d = rmsn_pkg::ST_MSDIV;
          end
        end
      end
      rmsn_pkg::ST_MSDIV: begin
        dnum_d = {dnum_q[DV_W-2:0], q_bit};
        drem_d = rem_nx[RT_W-1:0];
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DV_W - 1)) begin
          sval_d  = SQ_W'({dnum_q[DV_W-2:0], q_bit}) + SQ_W'(eps_q);
          srem_d  = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = rmsn_pkg::ST_SQRT;
        end
      end
      rmsn_pkg::ST_SQRT: begin
        sval_d = {sval_q[SQ_W-3:0], 2'b00};
        srem_d = s_ge ? (s_rem_t - s_trial) : s_rem_t;
        root_d = {root_q[RT_W-2:0], s_ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(RT_W - 1)) begin
          idx_d   = '0;
          state_d = rmsn_pkg::ST_RD;
        end
      end
      rmsn_pkg::ST_RD: begin
        state_d = rmsn_pkg::ST_MUL;
      end
      rmsn_pkg::ST_MUL: begin
        neg_d   = prod[PROD_W-1];
        mag_d   = prod[PROD_W-1] ? (PROD_W'(0) - $unsigned(prod)) : $unsigned(prod);
        state_d = rmsn_pkg::ST_PREP;
      end
      rmsn_pkg::ST_PREP: begin
        // numerator rounds half away from zero
        dnum_d  = DV_W'(mag_q) + DV_W'(root_q >> 1);
        drem_d  = '0;
        dvs_d   = root_q;
        step_d  = '0;
        state_d = rmsn_pkg::ST_DIV;
      end
      rmsn_pkg::ST_DIV: begin
        dnum_d = {dnum_q[DV_W-2:0], q_bit};
        drem_d = rem_nx[RT_W-1:0];
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DV_W - 1)) begin
          state_d = rmsn_pkg::ST_OUT;
        end
      end
      rmsn_pkg::ST_OUT: begin
        if (out_free) begin
          ov_d  = 1'b1;
          eov_d = (idx_q == cnt_q - 1'b1);
          trn_d = ovf_q;
          priority if (root_q == '0) begin
            res_d = '0;
          end else if (neg_q) begin
            res_d = (dnum_q > MaxNeg) ? MaxNeg[DATA_WIDTH-1:0]
                                      : DATA_WIDTH'(DV_W'(0) - dnum_q);
          end else begin
            res_d = (dnum_q > MaxPos) ? MaxPos[DATA_WIDTH-1:0] : dnum_q[DATA_WIDTH-1:0];
          end
          if (idx_q == cnt_q - 1'b1) begin
            sum_d   = '0;
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = rmsn_pkg::ST_LOAD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = rmsn_pkg::ST_RD;
          end
        end
      end
      default: state_d = rmsn_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmsn_pkg::ST_LOAD;
      eps_q   <= rmsn_pkg::EpsReset;
      sum_q   <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
      step_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      eps_q   <= eps_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dnum_q <= dnum_d;
    drem_q <= drem_d;
    dvs_q  <= dvs_d;
    sval_q <= sval_d;
    srem_q <= srem_d;
    root_q <= root_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    eov_q  <= eov_d;
    trn_q  <= trn_d;
  end

  assign out_valid_o     = ov_q;
  assign normalized_o    = res_q;
  assign end_of_vector_o = eov_q;
  assign truncated_o     = trn_q;

endmodule

// ===== hw/rtl/rmsn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rmsn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rmsn_checker.sv =====
// Port-level checker for the RMS normalizer, bound to the top level.
`include "assert_macros.svh"

module rmsn_checker #(
  parameter int unsigned DATA_WIDTH = rmsn_pkg::DataWidthDefault
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  final_req_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [DATA_WIDTH-1:0] normalized_o,
  input logic                  end_of_vector_o
);

  `RN_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")
  `RN_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(normalized_o), "result changed under stall")
  `RN_ASSERT(a_final_stalls, in_valid_i && !in_stall_o && final_req_i |=> in_stall_o, "input open after final element")
  `RN_ASSERT(a_last_gap, out_valid_o && !out_stall_i && end_of_vector_o |=> !out_valid_o, "result right after last of vector")

endmodule

bind rms_normalizer rmsn_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rmsn_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .final_req_i    (final_req_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .normalized_o   (normalized_o),
  .end_of_vector_o(end_of_vector_o)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the RMS normalizer with a fixed-point predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned VecCap    = 64;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
    logic               trunc;
  } norm_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          epsilon_we_i = 1'b0;
  logic [rmsn_pkg::EpsWidth-1:0] epsilon_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [15:0]            sample_i = '0;
  logic signed [15:0]            gain_i = '0;
  logic                          final_req_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [15:0]            normalized_o;
  logic                          end_of_vector_o;
  logic                          truncated_o;

  // predictor state
  logic [rmsn_pkg::EpsWidth-1:0] eps_shadow;
  logic signed [15:0]  vec_samples [VecCap];
  logic signed [15:0]  vec_gains [VecCap];
  longint unsigned     sq_total;
  int                  vec_len;
  bit                  vec_dropped;

  norm_result_t        pending_q [$];
  int                  fail_count = 0;
  int                  items_sent = 0;
  bit                  tx_idle_en = 1'b1;
  bit                  rx_idle_en = 1'b1;
  bit                  hold_req = 1'b0;
  int                  hold_cnt = 0;
  int unsigned         cycle_count = 0;

  rms_normalizer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .epsilon_we_i   (epsilon_we_i),
    .epsilon_i      (epsilon_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .gain_i         (gain_i),
    .final_req_i    (final_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .normalized_o   (normalized_o),
    .end_of_vector_o(end_of_vector_o),
    .truncated_o    (truncated_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [15:0] scale_elem(input logic signed [15:0] x,
                                                    input logic signed [15:0] w,
                                                    input longint unsigned rms);
    longint          prod;
    longint unsigned mag;
    longint unsigned quo;
    prod = longint'(x) * longint'(w);
    mag  = (prod < 0) ? longint'(-prod) : longint'(prod);
    if (rms == 0) return '0;
    quo = (mag + (rms >> 1)) / rms;
    if (prod < 0) return (quo > 32768) ? -16'sd32768 : -$signed(quo[15:0]);
    return (quo > 32767) ? 16'sd32767 : $signed(quo[15:0]);
  endfunction

  // Update the vector state for one accepted transaction; queue results on the final one.
  task automatic predict_vector(input logic signed [15:0] x, input logic signed [15:0] w,
                                input bit fin);
    longint unsigned mean_sq;
    longint unsigned rms;
    norm_result_t    res;
    if (vec_len < VecCap) begin
      vec_samples[vec_len] = x;
      vec_gains[vec_len]   = w;
      sq_total += longint'(longint'(x) * longint'(x));
      vec_len++;
    end else begin
      vec_dropped = 1'b1;
    end
    if (!fin) return;
    mean_sq = ((vec_len != 0) ? sq_total / vec_len : 0) + eps_shadow;
    rms = floor_sqrt(mean_sq);
    for (int i = 0; i < vec_len; i++) begin
      res.value = scale_elem(vec_samples[i], vec_gains[i], rms);
      res.last  = (i + 1 == vec_len);
      res.trunc = vec_dropped;
      pending_q.push_back(res);
    end
    sq_total    = 0;
    vec_len     = 0;
    vec_dropped = 1'b0;
  endtask

  task automatic send_item(input logic signed [15:0] x, input logic signed [15:0] w,
                           input bit fin);
    if (tx_idle_en && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_i    <= x;
    gain_i      <= w;
    final_req_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    predict_vector(x, w, fin);
    items_sent++;
  endtask

  // Stop offering and hold until every expected result has arrived.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_epsilon(input logic [rmsn_pkg::EpsWidth-1:0] value);
    drain_results();
    epsilon_we_i <= 1'b1;
    epsilon_i    <= value;
    @(posedge clk_i);
    epsilon_we_i <= 1'b0;
    eps_shadow = value;
  endtask

  function automatic logic signed [15:0] rand_q412();
    case ($urandom_range(0, 5))
      0:       return 16'sd32767;
      1:       return -16'sd32768;
      2:       return $signed(16'($urandom_range(0, 8191)) - 16'd4096);
      3:       return '0;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic send_random_vector(input int len);
    for (int i = 0; i < len; i++) send_item(rand_q412(), rand_q412(), i == len - 1);
  endtask

  // Check each result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    norm_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %0d", $time, normalized_o);
        fail_count++;
      end else begin
        exp_res = pending_q.pop_front();
        if (normalized_o !== exp_res.value) begin
          $display("%0t: normalized exp %0d got %0d", $time, exp_res.value, normalized_o);
          fail_count++;
        end
        if (end_of_vector_o !== exp_res.last) begin
          $display("%0t: end_of_vector exp %0b got %0b", $time, exp_res.last,
                   end_of_vector_o);
          fail_count++;
        end
        if (truncated_o !== exp_res.trunc) begin
          $display("%0t: truncated exp %0b got %0b", $time, exp_res.trunc, truncated_o);
          fail_count++;
        end
      end
    end
  end

  // Drive the receiver stall: random idling, or a long hold when requested.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rx_idle_en && ($urandom_range(0, 99) < 14);
    end
  end

  task automatic test_extremes();
    send_item(16'sd32767, 16'sd32767, 1'b1);
    send_item(-16'sd32768, -16'sd32768, 1'b1);
    send_item(-16'sd32768, 16'sd32767, 1'b1);
    send_item(16'sd1, -16'sd1, 1'b1);
    send_item(16'sd32767, 16'sd4096, 1'b0);
    send_item(16'sd1, 16'sd32767, 1'b0);
    send_item(-16'sd1, -16'sd32768, 1'b0);
    send_item(16'sd0, 16'sd4096, 1'b1);
    send_item(16'sh5555, 16'shAAAA, 1'b0);
    send_item(16'shAAAA, 16'sh5555, 1'b1);
  endtask

  task automatic test_epsilon();
    // zero epsilon with an all-zero vector gives a zero rms
    write_epsilon('0);
    send_item(16'sd0, 16'sd32767, 1'b0);
    send_item(16'sd0, -16'sd32768, 1'b1);
    send_item(16'sd3, 16'sd4096, 1'b0);
    send_item(-16'sd2, 16'sd100, 1'b1);
    write_epsilon(16'hFFFF);
    send_item(16'sd1, 16'sd32767, 1'b0);
    send_item(-16'sd40, -16'sd32768, 1'b1);
    send_item(16'sd0, 16'sd0, 1'b1);
    write_epsilon(16'd17);
  endtask

  task automatic test_overflow();
    // the dropped final element still ends the vector
    send_random_vector(66);
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_req = 1'b1;
    send_random_vector(6);
    send_random_vector(5);
    drain_results();
  endtask

  task automatic test_random();
    int len;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random_vector(3);
    send_random_vector(5);
    drain_results();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    while (items_sent < 220) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
      send_random_vector(len);
      if ($urandom_range(0, 7) == 0) write_epsilon(16'($urandom));
    end
  endtask

  initial begin
    eps_shadow  = rmsn_pkg::EpsReset;
    sq_total    = 0;
    vec_len     = 0;
    vec_dropped = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_epsilon();
    test_overflow();
    test_backpressure();
    test_random();
    drain_results();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rmsn_pkg.sv
hw/rtl/rmsn_ram.sv
hw/rtl/rms_normalizer.sv
hw/rtl/rmsn_checker.sv
tb/sv/testbench.sv
